// ===== design/dual_led_gamma_pwm_mixer_assert.svh =====
// Assertion macros shared by the checker of the LED dimmer.
// No dependencies; the including scope must provide clk and arst_n.
`ifndef DUAL_LED_GAMMA_PWM_MIXER_ASSERT_SVH
`define DUAL_LED_GAMMA_PWM_MIXER_ASSERT_SVH

// Condition in this cycle implies a consequence in the next cycle.
`define DLGPM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dlgpm assertion failed");

// Condition in this cycle implies a consequence in the same cycle.
`define DLGPM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlgpm assertion failed");

`endif

// ===== design/dlgpm_pkg.sv =====
// Package of the LED dimmer: command and register codes, state types and
// the constant table of the exponent unit. No dependencies.
package dlgpm_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int GAMMA_SCALE = 1000;
	localparam int DIV_BITS    = 48;

	// The scaled logarithm stays below 2^LG_BITS, so a multiply by this rounded-up
	// reciprocal and a right shift give its exact quotient by GAMMA_SCALE.
	localparam int          LG_BITS     = 37;
	localparam int          RECIP_SHIFT = LG_BITS + $clog2(GAMMA_SCALE);
	localparam logic [37:0] RECIP_GAMMA = 38'(((64'd1 << RECIP_SHIFT) +
		64'(GAMMA_SCALE - 1)) / 64'(GAMMA_SCALE));

	localparam logic [15:0] RST_BRIGHT_RANGE = 16'd1000;
	localparam logic [15:0] RST_BOUND_LEVEL  = 16'd1000;
	localparam logic [15:0] RST_BOUND_SCALE  = 16'd1000;
	localparam logic [15:0] RST_PROP_RANGE   = 16'd1000;
	localparam logic [15:0] RST_GAMMA        = 16'd2200;
	localparam logic [15:0] RST_PERIOD       = 16'd1000;

	typedef enum logic [2:0] {
		KIND_SET_BRIGHT = 3'd0,
		KIND_INC_BRIGHT = 3'd1,
		KIND_DEC_BRIGHT = 3'd2,
		KIND_SET_MIX    = 3'd3,
		KIND_INC_MIX    = 3'd4,
		KIND_DEC_MIX    = 3'd5
	} kind_e;

	typedef enum logic [2:0] {
		REG_BRIGHT_RANGE = 3'd0,
		REG_BOUND_LEVEL  = 3'd1,
		REG_BOUND_SCALE  = 3'd2,
		REG_PROP_RANGE   = 3'd3,
		REG_GAMMA        = 3'd4,
		REG_PERIOD       = 3'd5
	} reg_idx_e;

	typedef struct packed {
		logic [15:0] bright;
		logic [15:0] mix;
	} cmd_t;

	typedef struct packed {
		logic [15:0] bright_range;
		logic [15:0] bound_level;
		logic [15:0] bound_scale;
		logic [15:0] prop_range;
		logic [15:0] gamma;
		logic [15:0] period;
	} cfg_t;

	typedef enum logic [4:0] {
		B_IDLE, B_NUM, B_DEN, B_XGO, B_XDIV, B_GCHK, B_NORM, B_SQR, B_LMUL,
		B_EGO, B_EDIV, B_EXP, B_SHIFT, B_TMUL, B_PMUL, B_PGO, B_PDIV, B_OUT
	} back_state_t;

	typedef logic [15:0][15:0] d_tab_t;

	// Successive truncated square roots of one half in Q0.16.
	function automatic d_tab_t make_d_tab();
		d_tab_t      tab;
		logic [63:0] d;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bitv;
		tab = '0;
		d = 64'd32768;
		for (int k = 0; k < 16; k++) begin
			v = d << FRAC_BITS;
			res = 64'd0;
			bitv = 64'd1 << 62;
			for (int j = 0; j < 32; j++) begin
				if (v >= res + bitv) begin
					v = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			d = res;
			tab[k] = d[15:0];
		end
		return tab;
	endfunction

	localparam d_tab_t D_TAB = make_d_tab();

endpackage

// ===== design/dlgpm_front.sv =====
// Front end of the LED dimmer: accepts commands, updates the stored levels
// and pushes them to the queue. Depends on dlgpm_pkg.
module dlgpm_front import dlgpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [15:0] amount,
	input  logic [15:0] bright_range,
	input  logic [15:0] prop_range,
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_data
);

	logic [15:0] bright_q;
	logic [15:0] mix_q;
	logic [15:0] bright_d;
	logic [15:0] mix_d;
	logic [15:0] step;
	logic [16:0] b_sum;
	logic [16:0] m_sum;
	logic [15:0] b_sat;
	logic [15:0] m_sat;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign step     = (amount == 16'd0) ? 16'd1 : amount;
	assign b_sum    = {1'b0, bright_q} + {1'b0, step};
	assign m_sum    = {1'b0, mix_q} + {1'b0, step};
	assign b_sat    = b_sum[16] ? 16'hFFFF : b_sum[15:0];
	assign m_sat    = m_sum[16] ? 16'hFFFF : m_sum[15:0];

	always_comb begin
		bright_d = bright_q;
		mix_d    = mix_q;
		case (kind)
			KIND_SET_BRIGHT: bright_d = (amount < bright_range) ? amount : bright_range;
			KIND_INC_BRIGHT: bright_d = (b_sat < bright_range) ? b_sat : bright_range;
			KIND_DEC_BRIGHT: bright_d = (step < bright_q) ? bright_q - step : 16'd0;
			KIND_SET_MIX:    mix_d = (amount < prop_range) ? amount : prop_range;
			KIND_INC_MIX:    mix_d = (m_sat < prop_range) ? m_sat : prop_range;
			KIND_DEC_MIX:    mix_d = (step < mix_q) ? mix_q - step : 16'd0;
			default: ;
		endcase
	end

	assign push_data.bright = bright_d;
	assign push_data.mix    = mix_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= '0;
			mix_q    <= '0;
		end else if (push) begin
			bright_q <= bright_d;
			mix_q    <= mix_d;
		end
	end

endmodule

// ===== design/dlgpm_queue.sv =====
// Two-entry queue between the front end and the back end of the dimmer.
// Depends on dlgpm_pkg.
module dlgpm_queue import dlgpm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic not_empty
);

	cmd_t        mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== design/dlgpm_div.sv =====
// Shared restoring divider of the dimmer, one quotient bit per cycle.
// Depends on dlgpm_pkg.
module dlgpm_div import dlgpm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [31:0]         divisor,
	output logic                done,
	output logic [DIV_BITS-1:0] quotient
);

	logic                busy_q;
	logic                done_q;
	logic [5:0]          cnt_q;
	logic [31:0]         rem_q;
	logic [31:0]         dvs_q;
	logic [DIV_BITS-1:0] dvd_q;
	logic [32:0]         shifted;
	logic                fits;
	logic [32:0]         diff;

	assign shifted  = {rem_q, dvd_q[DIV_BITS-1]};
	assign fits     = (shifted >= {1'b0, dvs_q});
	assign diff     = shifted - {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : shifted[31:0];
			dvd_q <= {dvd_q[DIV_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/dlgpm_back.sv =====
// Back end of the dimmer: sequencer for ratio, log2, gamma, exp2 and split,
// with the output register. Depends on dlgpm_pkg and dlgpm_div.
module dlgpm_back import dlgpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_not_empty,
	input  cmd_t        q_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] low_compare,
	output logic [15:0] high_compare,
	output logic [15:0] brightness_now,
	output logic [15:0] proportion_now
);

	localparam logic [16:0] ONE_Q  = 17'h10000;
	localparam logic [33:0] HALF_Q = 34'h8000;

	back_state_t         state_q;
	back_state_t         state_d;
	cmd_t                cur_q;
	logic [31:0]         num_q;
	logic [31:0]         den_q;
	logic [16:0]         xq_q;
	logic [16:0]         m_q;
	logic [4:0]          e_q;
	logic [15:0]         f_q;
	logic [3:0]          cnt_q;
	logic [36:0]         lg_q;
	logic [55:0]         elo_q;
	logic [26:0]         ee_q;
	logic [16:0]         r_q;
	logic [16:0]         y_q;
	logic [31:0]         t_q;
	logic [47:0]         tp_q;
	logic [31:0]         p0_q;
	logic                out_valid_q;
	logic [15:0]         low_q;
	logic [15:0]         high_q;
	logic [15:0]         bnow_q;
	logic [15:0]         pnow_q;

	logic                div_start;
	logic [DIV_BITS-1:0] div_dividend;
	logic [31:0]         div_divisor;
	logic                div_done;
	logic [DIV_BITS-1:0] div_quot;

	logic [15:0]         b_eff;
	logic [15:0]         bd_eff;
	logic [15:0]         pr_eff;
	logic [33:0]         sq_sum;
	logic [17:0]         sq;
	logic [20:0]         l_val;
	logic [36:0]         lg_next;
	logic [63:0]         e_acc;
	logic [32:0]         ex_sum;
	logic [10:0]         ip_full;
	logic [4:0]          ip_small;
	logic [17:0]         rnd_add;
	logic [17:0]         y_sh;
	logic [16:0]         y_next;
	logic [32:0]         t_prod;
	logic [31:0]         p1;
	logic [32:0]         u0;
	logic [32:0]         u1;
	logic [15:0]         u0c;
	logic                out_free;
	logic                out_load;

	dlgpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign b_eff   = (cur_q.bright < cfg.bright_range) ? cur_q.bright : cfg.bright_range;
	assign bd_eff  = (cfg.bound_level < cfg.bound_scale) ? cfg.bound_level : cfg.bound_scale;
	assign pr_eff  = (cur_q.mix < cfg.prop_range) ? cur_q.mix : cfg.prop_range;
	assign sq_sum  = ({17'd0, m_q} * {17'd0, m_q}) + HALF_Q;
	assign sq      = sq_sum[33:16];
	assign l_val   = {e_q, 16'd0} - {5'd0, f_q};
	assign lg_next = (37'(l_val) * 37'(cfg.gamma)) + 37'(GAMMA_SCALE / 2);
	assign e_acc   = {8'd0, {19'd0, lg_q} * {37'd0, RECIP_GAMMA[37:19]}} +
		{27'd0, elo_q[55:19]};
	assign ex_sum  = ({16'd0, r_q} * {17'd0, D_TAB[cnt_q]}) + HALF_Q[32:0];
	assign ip_full = ee_q[26:16];
	assign ip_small = ip_full[4:0];
	assign rnd_add = 18'd1 << (ip_small - 5'd1);
	assign y_sh    = ({1'b0, r_q} + rnd_add) >> ip_small;
	assign t_prod  = {16'd0, y_q} * {17'd0, cfg.period};
	assign p1      = t_q - p0_q;
	assign u0      = ({1'b0, p0_q} + HALF_Q[32:0]) >> 16;
	assign u1      = ({1'b0, p1} + HALF_Q[32:0]) >> 16;
	assign u0c     = (u0 > {17'd0, cfg.period}) ? cfg.period : u0[15:0];

	always_comb begin
		if (ip_full > 11'd16) begin
			y_next = '0;
		end else if (ip_full == 11'd0) begin
			y_next = r_q;
		end else begin
			y_next = y_sh[16:0];
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == B_OUT) && out_free;
	assign pop      = (state_q == B_IDLE) && q_not_empty;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = tp_q;
		div_divisor  = {16'd0, cfg.prop_range};
		unique case (state_q)
			B_XGO: begin
				div_start    = (den_q != 32'd0);
				div_dividend = {num_q, 16'd0};
				div_divisor  = den_q;
			end
			B_PGO: begin
				div_start = (cfg.prop_range != 16'd0);
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (q_not_empty) state_d = B_NUM;
			B_NUM:   state_d = B_DEN;
			B_DEN:   state_d = B_XGO;
			B_XGO:   state_d = (den_q != 32'd0) ? B_XDIV : B_GCHK;
			B_XDIV:  if (div_done) state_d = B_GCHK;
			B_GCHK: begin
				if (cfg.gamma == 16'd0 || xq_q == 17'd0) begin
					state_d = B_TMUL;
				end else begin
					state_d = B_NORM;
				end
			end
			B_NORM:  if (m_q[16]) state_d = B_SQR;
			B_SQR:   if (cnt_q == 4'd15) state_d = B_LMUL;
			B_LMUL:  state_d = B_EGO;
			B_EGO:   state_d = B_EDIV;
			B_EDIV:  state_d = B_EXP;
			B_EXP:   if (cnt_q == 4'd15) state_d = B_SHIFT;
			B_SHIFT: state_d = B_TMUL;
			B_TMUL:  state_d = B_PMUL;
			B_PMUL:  state_d = B_PGO;
			B_PGO:   state_d = (cfg.prop_range != 16'd0) ? B_PDIV : B_OUT;
			B_PDIV:  if (div_done) state_d = B_OUT;
			B_OUT:   if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cur_q <= q_data;
			end
			B_NUM: begin
				num_q <= {16'd0, b_eff} * {16'd0, bd_eff};
			end
			B_DEN: begin
				den_q <= {16'd0, cfg.bright_range} * {16'd0, cfg.bound_scale};
			end
			B_XGO: begin
				xq_q <= '0;
			end
			B_XDIV: begin
				if (div_done) begin
					xq_q <= (div_quot > DIV_BITS'(ONE_Q)) ? ONE_Q : div_quot[16:0];
				end
			end
			B_GCHK: begin
				m_q <= xq_q;
				e_q <= '0;
				f_q <= '0;
				cnt_q <= '0;
				y_q <= (cfg.gamma == 16'd0) ? ONE_Q : 17'd0;
			end
			B_NORM: begin
				if (!m_q[16]) begin
					m_q <= {m_q[15:0], 1'b0};
					e_q <= e_q + 5'd1;
				end
			end
			B_SQR: begin
				if (sq[17]) begin
					m_q <= sq[17:1];
					f_q[4'd15 - cnt_q] <= 1'b1;
				end else begin
					m_q <= sq[16:0];
				end
				cnt_q <= cnt_q + 4'd1;
			end
			B_LMUL: begin
				lg_q <= lg_next;
			end
			B_EGO: begin
				elo_q <= {19'd0, lg_q} * {37'd0, RECIP_GAMMA[18:0]};
			end
			B_EDIV: begin
				ee_q  <= e_acc[RECIP_SHIFT - 19 +: 27];
				r_q   <= ONE_Q;
				cnt_q <= '0;
			end
			B_EXP: begin
				if (ee_q[4'd15 - cnt_q]) begin
					r_q <= ex_sum[32:16];
				end
				cnt_q <= cnt_q + 4'd1;
			end
			B_SHIFT: begin
				y_q <= y_next;
			end
			B_TMUL: begin
				t_q <= t_prod[31:0];
			end
			B_PMUL: begin
				tp_q <= {16'd0, t_q} * {32'd0, pr_eff};
			end
			B_PGO: begin
				p0_q <= '0;
			end
			B_PDIV: begin
				if (div_done) begin
					p0_q <= div_quot[31:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			low_q  <= cfg.period - u0c;
			high_q <= u1[15:0];
			bnow_q <= cur_q.bright;
			pnow_q <= cur_q.mix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign low_compare    = low_q;
	assign high_compare   = high_q;
	assign brightness_now = bnow_q;
	assign proportion_now = pnow_q;

endmodule

// ===== design/dual_led_gamma_pwm_mixer.sv =====
// Two-channel warm/cool LED dimmer with gamma correction, top level.
// Holds the configuration registers. Depends on dlgpm_pkg and the sub-blocks.
//
// Commands arrive on the in channel (kind, amount) under valid/ready; each
// transfer updates the brightness or mix level at once and yields exactly one
// result on the out channel (both compare values and both levels).
// The configuration port writes one register per cycle with wr_en high; it
// should only be used while no command is in flight.
// Each command runs through two 48-step divisions (ratio and split) on the
// shared divider, normalising, 16 squaring steps and 16 exponent steps; the
// gamma scaling is a reciprocal multiply split over B_EGO and B_EDIV. A zero
// gamma or ratio skips the log2 and exp2 steps, and a zero brightness range,
// bound scale or proportion range skips a division. A new command starts
// only after the last result is loaded; a two-entry queue lets up to two
// further commands be taken while one is computed and one result waits.
// Reset clears both levels, restores the register defaults and empties the
// queue and output register. A stalled receiver holds the result steady, and
// the input side keeps accepting until the queue fills.
module dual_led_gamma_pwm_mixer import dlgpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [15:0] amount,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] low_compare,
	output logic [15:0] high_compare,
	output logic [15:0] brightness_now,
	output logic [15:0] proportion_now,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);

	cfg_t cfg_q;
	logic q_full;
	logic push;
	cmd_t push_data;
	logic pop;
	cmd_t pop_data;
	logic q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_range <= RST_BRIGHT_RANGE;
			cfg_q.bound_level  <= RST_BOUND_LEVEL;
			cfg_q.bound_scale  <= RST_BOUND_SCALE;
			cfg_q.prop_range   <= RST_PROP_RANGE;
			cfg_q.gamma        <= RST_GAMMA;
			cfg_q.period       <= RST_PERIOD;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BRIGHT_RANGE: cfg_q.bright_range <= wr_data;
				REG_BOUND_LEVEL:  cfg_q.bound_level  <= wr_data;
				REG_BOUND_SCALE:  cfg_q.bound_scale  <= wr_data;
				REG_PROP_RANGE:   cfg_q.prop_range   <= wr_data;
				REG_GAMMA:        cfg_q.gamma        <= wr_data;
				REG_PERIOD:       cfg_q.period       <= wr_data;
				default: ;
			endcase
		end
	end

	dlgpm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.amount       (amount),
		.bright_range (cfg_q.bright_range),
		.prop_range   (cfg_q.prop_range),
		.q_full       (q_full),
		.push         (push),
		.push_data    (push_data)
	);

	dlgpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	dlgpm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_not_empty    (q_not_empty),
		.q_data         (pop_data),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.low_compare    (low_compare),
		.high_compare   (high_compare),
		.brightness_now (brightness_now),
		.proportion_now (proportion_now)
	);

endmodule

// ===== design/dlgpm_checker.sv =====
// Port-level checker of the LED dimmer and its bind to the top level.
// Depends on dlgpm_pkg and dual_led_gamma_pwm_mixer_assert.svh.
`include "dual_led_gamma_pwm_mixer_assert.svh"

module dlgpm_checker import dlgpm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] low_compare,
	input logic [15:0] high_compare,
	input logic        wr_en,
	input logic [2:0]  wr_index,
	input logic [15:0] wr_data
);

	logic [2:0]  pending_q;
	logic [15:0] period_q;
	logic        in_xfer;
	logic        out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			period_q  <= RST_PERIOD;
		end else begin
			if (in_xfer && !out_xfer) begin
				pending_q <= pending_q + 3'd1;
			end else if (out_xfer && !in_xfer) begin
				pending_q <= pending_q - 3'd1;
			end
			if (wr_en && wr_index == REG_PERIOD) begin
				period_q <= wr_data;
			end
		end
	end

	`DLGPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(low_compare) && $stable(high_compare))
	`DLGPM_ASSERT_SAME(a_out_has_cmd, out_valid, pending_q != 3'd0)
	`DLGPM_ASSERT_SAME(a_in_room, in_xfer, pending_q < 3'd4)
	`DLGPM_ASSERT_SAME(a_cmp_bound, out_valid, low_compare <= period_q && high_compare <= period_q)

endmodule

bind dual_led_gamma_pwm_mixer dlgpm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.low_compare  (low_compare),
	.high_compare (high_compare),
	.wr_en        (wr_en),
	.wr_index     (wr_index),
	.wr_data      (wr_data)
);
